[src/pee_pkg.sv]
// Shared constants, token codes and controller/datapath interface types for the postfix evaluator.
package pee_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int LEVEL_W     = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int DATA_W      = 32;
    localparam int SYM_W       = 8;
    localparam int STAT_W      = 2;

    // Token characters
    localparam logic [SYM_W-1:0] CH_ZERO = 8'h30;
    localparam logic [SYM_W-1:0] CH_MUL  = 8'h2A;
    localparam logic [SYM_W-1:0] CH_DIV  = 8'h2F;
    localparam logic [SYM_W-1:0] CH_MOD  = 8'h25;
    localparam logic [SYM_W-1:0] CH_ADD  = 8'h2B;
    localparam logic [SYM_W-1:0] CH_SUB  = 8'h2D;
    localparam logic [SYM_W-1:0] CH_XOR  = 8'h5E;

    // Result status codes
    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_UNDERFLOW = 2'd1;
    localparam logic [STAT_W-1:0] ST_OVERFLOW  = 2'd2;
    localparam logic [STAT_W-1:0] ST_DIVZERO   = 2'd3;

    // Commands from controller to datapath
    typedef struct packed {
        logic capture;     // latch the accepted item
        logic push;        // push the token value
        logic underflow;   // operator on a short stack
        logic op_read;     // fetch the entry below the top
        logic op_apply;    // write back an ALU operator result
        logic div_zero;    // divide by zero: pop both, flag error
        logic div_start;   // launch the divider
        logic div_write;   // write back the divider result
        logic finish;      // emit result and clear the stack
    } pee_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic err_set;
        logic is_op;
        logic is_div;
        logic level_lt2;
        logic x_zero;
        logic div_done;
        logic eol;
    } pee_stat_t;

endpackage

[src/pee_div.sv]
// Iterative signed 32-bit divider, one quotient bit per cycle, giving quotient or remainder.
module pee_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [pee_pkg::DATA_W-1:0] dividend,
    input  logic [pee_pkg::DATA_W-1:0] divisor,
    input  logic                       want_rem,
    output logic                       done,
    output logic [pee_pkg::DATA_W-1:0] result
);
    import pee_pkg::*;

    localparam int CNT_W = $clog2(DATA_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DATA_W-1:0] q_reg, q_next;
    logic [DATA_W-1:0] r_reg, r_next;
    logic [DATA_W-1:0] d_reg, d_next;
    logic              negq_reg, negq_next;
    logic              negr_reg, negr_next;
    logic              rem_reg, rem_next;

    logic [DATA_W:0]   shifted;
    logic [DATA_W:0]   trial;

    // Restoring step
    assign shifted = {r_reg, q_reg[DATA_W-1]};
    assign trial   = shifted - {1'b0, d_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        negq_next = negq_reg;
        negr_next = negr_reg;
        rem_next  = rem_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DATA_W - 1);
            q_next    = dividend[DATA_W-1] ? (~dividend + 1'b1) : dividend;
            r_next    = '0;
            d_next    = divisor[DATA_W-1] ? (~divisor + 1'b1) : divisor;
            negq_next = dividend[DATA_W-1] ^ divisor[DATA_W-1];
            negr_next = dividend[DATA_W-1];
            rem_next  = want_rem;
        end
        else if (busy_reg)
        begin
            if (!trial[DATA_W])
            begin
                r_next = trial[DATA_W-1:0];
                q_next = {q_reg[DATA_W-2:0], 1'b1};
            end
            else
            begin
                r_next = shifted[DATA_W-1:0];
                q_next = {q_reg[DATA_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        cnt_reg  <= cnt_next;
        q_reg    <= q_next;
        r_reg    <= r_next;
        d_reg    <= d_next;
        negq_reg <= negq_next;
        negr_reg <= negr_next;
        rem_reg  <= rem_next;
    end

    // Sign correction: quotient by operand signs, remainder follows the dividend
    always_comb
    begin
        if (rem_reg)
            result = negr_reg ? (~r_reg + 1'b1) : r_reg;
        else
            result = negq_reg ? (~q_reg + 1'b1) : q_reg;
    end

    assign done = done_reg;

endmodule

[src/pee_datapath.sv]
// Operand stack (cached top plus memory), ALU, divider and result registers.
module pee_datapath (
    input  logic                       clk,
    input  logic                       rst_n,
    input  pee_pkg::pee_cmd_t          cmd,
    output pee_pkg::pee_stat_t         stat,
    input  logic [pee_pkg::SYM_W-1:0]  symbol,
    input  logic                       end_of_expression,
    output logic [pee_pkg::DATA_W-1:0] value,
    output logic [pee_pkg::STAT_W-1:0] status
);
    import pee_pkg::*;

    logic [SYM_W-1:0]   sym_reg;
    logic               eol_reg;
    logic [DATA_W-1:0]  tos_reg, tos_next;
    logic [LEVEL_W-1:0] level_reg, level_next;
    logic [STAT_W-1:0]  err_reg, err_next;
    logic [DATA_W-1:0]  value_reg, value_next;
    logic [STAT_W-1:0]  status_reg, status_next;

    // Entries below the top; the top itself lives in tos_reg
    logic [DATA_W-1:0]  stack_mem [STACK_DEPTH];
    logic [DATA_W-1:0]  rd_data_reg;

    logic [LEVEL_W-1:0] level_m1;
    logic [LEVEL_W-1:0] level_m2;
    logic               full;
    logic               wr_en;
    logic [DATA_W-1:0]  push_val;
    logic [DATA_W-1:0]  prod;
    logic [DATA_W-1:0]  alu_res;
    logic [DATA_W-1:0]  div_res;
    logic               div_done;
    logic               tok_is_op;
    logic               tok_is_div;

    assign level_m1 = level_reg - 1'b1;
    assign level_m2 = level_reg - 2'd2;
    assign full     = (level_reg == LEVEL_W'(STACK_DEPTH));
    assign push_val = {{(DATA_W-SYM_W){1'b0}}, sym_reg} - {{(DATA_W-SYM_W){1'b0}}, CH_ZERO};
    assign wr_en    = cmd.push && !full && (level_reg != '0);

    // Token decode
    always_comb
    begin
        tok_is_op  = 1'b0;
        tok_is_div = 1'b0;
        case (sym_reg)
            CH_MUL, CH_ADD, CH_SUB, CH_XOR:
                tok_is_op = 1'b1;
            CH_DIV, CH_MOD:
            begin
                tok_is_op  = 1'b1;
                tok_is_div = 1'b1;
            end
            default:
                tok_is_op = 1'b0;
        endcase
    end

    assign stat.is_op     = tok_is_op;
    assign stat.is_div    = tok_is_div;
    assign stat.err_set   = (err_reg != ST_OK);
    assign stat.level_lt2 = (level_reg < LEVEL_W'(2));
    assign stat.x_zero    = (tos_reg == '0);
    assign stat.div_done  = div_done;
    assign stat.eol       = eol_reg;

    // ALU operators: x is the top, y the entry below
    assign prod = tos_reg * rd_data_reg;
    always_comb
    begin
        case (sym_reg)
            CH_MUL:  alu_res = prod[DATA_W-1:0];
            CH_ADD:  alu_res = rd_data_reg + tos_reg;
            CH_SUB:  alu_res = rd_data_reg - tos_reg;
            CH_XOR:  alu_res = rd_data_reg ^ tos_reg;
            default: alu_res = '0;
        endcase
    end

    pee_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (rd_data_reg),
        .divisor  (tos_reg),
        .want_rem (sym_reg == CH_MOD),
        .done     (div_done),
        .result   (div_res)
    );

    // Stack, error and result update
    always_comb
    begin
        tos_next    = tos_reg;
        level_next  = level_reg;
        err_next    = err_reg;
        value_next  = value_reg;
        status_next = status_reg;
        if (cmd.push)
        begin
            if (full)
                err_next = ST_OVERFLOW;
            else
            begin
                tos_next   = push_val;
                level_next = level_reg + 1'b1;
            end
        end
        if (cmd.underflow)
            err_next = ST_UNDERFLOW;
        if (cmd.op_apply)
        begin
            tos_next   = alu_res;
            level_next = level_m1;
        end
        if (cmd.div_zero)
        begin
            err_next   = ST_DIVZERO;
            level_next = level_m2;
        end
        if (cmd.div_write)
        begin
            tos_next   = div_res;
            level_next = level_m1;
        end
        if (cmd.finish)
        begin
            if (err_reg != ST_OK)
            begin
                value_next  = '0;
                status_next = err_reg;
            end
            else if (level_reg == '0)
            begin
                value_next  = '0;
                status_next = ST_UNDERFLOW;
            end
            else
            begin
                value_next  = tos_reg;
                status_next = ST_OK;
            end
            level_next = '0;
            err_next   = ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= '0;
            err_reg   <= ST_OK;
        end
        else
        begin
            level_reg <= level_next;
            err_reg   <= err_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            sym_reg <= symbol;
            eol_reg <= end_of_expression;
        end
        tos_reg    <= tos_next;
        value_reg  <= value_next;
        status_reg <= status_next;
    end

    // Stack memory: old top spills on push, entry below top read for operators
    always_ff @(posedge clk)
    begin
        if (wr_en)
            stack_mem[level_m1[ADDR_W-1:0]] <= tos_reg;
        if (cmd.op_read)
            rd_data_reg <= stack_mem[level_m2[ADDR_W-1:0]];
    end

    assign value  = value_reg;
    assign status = status_reg;

endmodule

[src/pee_ctrl.sv]
// Controller state machine: sequences one token at a time and owns both handshakes.
module pee_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  pee_pkg::pee_stat_t stat,
    output pee_pkg::pee_cmd_t  cmd
);
    import pee_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_OPER   = 3'd2;
    localparam logic [2:0] S_DIV    = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                // Tokens after an error are skipped until the end item
                if (stat.err_set)
                    state_next = S_FINISH;
                else if (stat.is_op)
                begin
                    if (stat.level_lt2)
                    begin
                        cmd.underflow = 1'b1;
                        state_next    = S_FINISH;
                    end
                    else
                    begin
                        cmd.op_read = 1'b1;
                        state_next  = S_OPER;
                    end
                end
                else
                begin
                    cmd.push   = 1'b1;
                    state_next = S_FINISH;
                end
            end
            S_OPER:
            begin
                if (!stat.is_div)
                begin
                    cmd.op_apply = 1'b1;
                    state_next   = S_FINISH;
                end
                else if (stat.x_zero)
                begin
                    cmd.div_zero = 1'b1;
                    state_next   = S_FINISH;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV:
            begin
                if (stat.div_done)
                begin
                    cmd.div_write = 1'b1;
                    state_next    = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (!stat.eol)
                    state_next = S_IDLE;
                else if (out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // Output valid: set on emit, cleared when taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (cmd.finish)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

[src/postfix_expression_evaluator_top.sv]
// Top level of the postfix expression evaluator: controller plus datapath on stream ports.
//
//  Channel  | Dir | tdata              | tuser       | tlast
//  ---------+-----+--------------------+-------------+-------------------
//  s_axis   | in  | [7:0] symbol       | -           | end_of_expression
//  m_axis   | out | [31:0] value       | [1:0] status| -
//
// Pushes, skipped tokens and underflows pass the decode and finish states; +, -, *, ^ and
// divide by zero also pass the operand state; other / and % wait in the divide state for the
// divider, one quotient bit a cycle. An end item waits only while the last result is not yet
// taken. Reset clears the stack level, error and handshake state; the stack memory is not
// cleared. A result waiting on m_axis does not block new items; only the next end item waits.
module postfix_expression_evaluator_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] symbol
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] value
    output logic [1:0]  m_axis_tuser    // [1:0] status
);
    import pee_pkg::*;

    pee_cmd_t  cmd;
    pee_stat_t stat;

    pee_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .stat      (stat),
        .cmd       (cmd)
    );

    pee_datapath u_dp (
        .clk               (clk),
        .rst_n             (rst_n),
        .cmd               (cmd),
        .stat              (stat),
        .symbol            (s_axis_tdata),
        .end_of_expression (s_axis_tlast),
        .value             (m_axis_tdata),
        .status            (m_axis_tuser)
    );

endmodule

[verif/tb_postfix_expression_evaluator_top.sv]
// Self-checking testbench for the postfix expression evaluator: token streams against a stack predictor.
module tb_postfix_expression_evaluator_top;
    import pee_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int RANDOM_ITEMS  = 700;
    localparam int DRAIN_CYCLES  = 60;
    localparam int TIMEOUT_TICKS = 24_000_000;

    // 128 above '0' pushes 2**7, used to build the most negative value
    localparam logic [SYM_W-1:0] CH_POW7 = CH_ZERO + 8'd128;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic [STAT_W-1:0] status;
    } eval_result_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [7:0]        s_axis_tdata = '0;   // [7:0] symbol
    logic              s_axis_tlast = 1'b0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [31:0]       m_axis_tdata;        // [31:0] value
    logic [1:0]        m_axis_tuser;        // [1:0] status

    // Predictor state
    logic [DATA_W-1:0] model_stack [STACK_DEPTH];
    int unsigned       model_level = 0;
    logic [STAT_W-1:0] model_error = ST_OK;
    eval_result_t      pending_results[$];

    // Tokens waiting to be sent, bit 8 is the end flag
    logic [8:0]        token_script[$];
    int                fail_count = 0;
    int                live_items = 0;
    bit                steady_source = 1'b0;

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    postfix_expression_evaluator_top dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    function automatic bit is_operator(input logic [SYM_W-1:0] c);
        return c == CH_MUL || c == CH_DIV || c == CH_MOD || c == CH_ADD ||
               c == CH_SUB || c == CH_XOR;
    endfunction

    // First error of an expression sticks
    function automatic void note_fault(input logic [STAT_W-1:0] code);
        if (model_error == ST_OK)
            model_error = code;
    endfunction

    function automatic void model_push(input logic [DATA_W-1:0] v);
        if (model_level >= STACK_DEPTH)
        begin
            note_fault(ST_OVERFLOW);
        end
        else
        begin
            model_stack[model_level] = v;
            model_level++;
        end
    endfunction

    // Pop x (top) and y (next), push y op x
    function automatic void model_operator(input logic [SYM_W-1:0] op);
        logic [DATA_W-1:0] x, y, mx, my, q, r;
        if (model_level < 2)
        begin
            note_fault(ST_UNDERFLOW);
            return;
        end
        x = model_stack[model_level - 1];
        y = model_stack[model_level - 2];
        model_level -= 2;
        r = '0;
        case (op)
            CH_MUL: r = y * x;
            CH_ADD: r = y + x;
            CH_SUB: r = y - x;
            CH_XOR: r = y ^ x;
            default:
            begin
                // operands stay popped on divide by zero
                if (x == '0)
                begin
                    note_fault(ST_DIVZERO);
                    return;
                end
                mx = x[DATA_W-1] ? -x : x;
                my = y[DATA_W-1] ? -y : y;
                if (op == CH_DIV)
                begin
                    q = my / mx;
                    r = (x[DATA_W-1] != y[DATA_W-1]) ? -q : q;
                end
                else
                begin
                    q = my % mx;
                    r = y[DATA_W-1] ? -q : q;
                end
            end
        endcase
        model_push(r);
    endfunction

    // Returns 1 when the token was evaluated rather than skipped after an error
    function automatic bit model_token(input logic [SYM_W-1:0] sym, input logic eoe);
        bit           live;
        eval_result_t res;
        live = (model_error == ST_OK);
        if (live)
        begin
            if (is_operator(sym))
                model_operator(sym);
            else
                model_push({24'd0, sym} - {24'd0, CH_ZERO});
        end
        if (eoe)
        begin
            if (model_error == ST_OK && model_level == 0)
                model_error = ST_UNDERFLOW;
            res.status = model_error;
            if (model_error == ST_OK)
                res.value = model_stack[model_level - 1];
            else
                res.value = '0;
            pending_results.push_back(res);
            model_level = 0;
            model_error = ST_OK;
        end
        return live;
    endfunction

    // Compare every result with the oldest expectation
    always @(posedge clk)
    begin : result_check
        eval_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: value %0d status %0d",
                       $signed(m_axis_tdata), m_axis_tuser);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_axis_tuser !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, m_axis_tuser);
                    fail_count++;
                end
                if (m_axis_tdata !== want.value)
                begin
                    $error("value: expected %0d, got %0d",
                           $signed(want.value), $signed(m_axis_tdata));
                    fail_count++;
                end
            end
        end
    end

    // Result side backpressure: mostly short ready stretches with some long ones, mostly short or no stalls, a few long
    initial
    begin : sink_pacing
        int run;
        int hold;
        int r;
        @(posedge clk);
        forever
        begin
            r = $urandom_range(0, 99);
            if (r < 15)
                run = $urandom_range(100, 300);
            else
                run = $urandom_range(1, 6);
            r = $urandom_range(0, 99);
            if (r < 40)
                hold = 0;
            else if (r < 90)
                hold = $urandom_range(1, 4);
            else
                hold = $urandom_range(20, 80);
            m_axis_tready <= 1'b1;
            repeat (run) @(posedge clk);
            if (hold > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
        end
    end

    function automatic int source_gap();
        int r;
        if (steady_source)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Present one token and hold it until accepted
    task automatic send_token(input logic [SYM_W-1:0] sym, input logic eoe);
        int gap;
        gap = source_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= sym;
        s_axis_tlast  <= eoe;
        if (model_token(sym, eoe))
            live_items++;
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    function automatic void add_token(input logic [SYM_W-1:0] sym);
        token_script.push_back({1'b0, sym});
    endfunction

    function automatic void add_text(input string s);
        for (int i = 0; i < s.len(); i++)
            add_token(s[i]);
    endfunction

    function automatic void close_expression();
        logic [8:0] t;
        t = token_script.pop_back();
        token_script.push_back({1'b1, t[7:0]});
    endfunction

    task automatic run_script();
        logic [8:0] t;
        while (token_script.size() > 0)
        begin
            t = token_script.pop_front();
            send_token(t[7:0], t[8]);
        end
    endtask

    task automatic send_text(input string s);
        add_text(s);
        close_expression();
        run_script();
    endtask

    function automatic logic [SYM_W-1:0] random_operand();
        logic [SYM_W-1:0] c;
        if ($urandom_range(0, 9) < 7)
            return CH_ZERO + 8'($urandom_range(0, 9));
        do
            c = 8'($urandom_range(0, 255));
        while (is_operator(c));
        return c;
    endfunction

    function automatic logic [SYM_W-1:0] random_operator();
        case ($urandom_range(0, 5))
            0:       return CH_MUL;
            1:       return CH_DIV;
            2:       return CH_MOD;
            3:       return CH_ADD;
            4:       return CH_SUB;
            default: return CH_XOR;
        endcase
    endfunction

    // Valid postfix order with random operands and operators
    function automatic void add_well_formed(input int operands);
        int depth;
        int used;
        depth = 0;
        used  = 0;
        while (used < operands || depth > 1)
        begin
            if (used < operands && (depth < 2 || $urandom_range(0, 2) != 0))
            begin
                add_token(random_operand());
                used++;
                depth++;
            end
            else
            begin
                add_token(random_operator());
                depth--;
            end
        end
    endfunction

    // 128^4 * 8 wraps to the most negative value
    function automatic void add_int_min();
        add_token(CH_POW7);
        add_token(CH_POW7);
        add_token(CH_MUL);
        add_token(CH_POW7);
        add_token(CH_MUL);
        add_token(CH_POW7);
        add_token(CH_MUL);
        add_text("8*");
    endfunction

    task automatic test_operators();
        send_text("97*");
        send_text("97/");
        send_text("97%");
        send_text("97+");
        send_text("97-");
        send_text("97^");
        // signed divide and remainder
        send_text("09-7/");
        send_text("09-7%");
        send_text("709-%");
        send_text("09-07-*");
    endtask

    task automatic test_field_extremes();
        add_token(8'h00);
        close_expression();
        add_token(8'hFF);
        close_expression();
        add_token(8'hFF);
        add_token(8'h00);
        add_token(CH_SUB);
        close_expression();
        run_script();
        send_text("9");
    endtask

    task automatic test_error_cases();
        // underflow with one and with no value
        send_text("5+");
        send_text("+");
        // divide and remainder by zero
        send_text("50/");
        send_text("50%");
        send_text("555-/");
        // first error is kept, the rest ignored
        send_text("50/34+");
        send_text("+12+");
    endtask

    task automatic test_wrap_cases();
        // most negative over -1: quotient wraps, remainder zero
        add_int_min();
        add_text("01-/");
        close_expression();
        add_int_min();
        add_text("01-%");
        close_expression();
        add_int_min();
        add_text("1-");
        close_expression();
        add_int_min();
        add_int_min();
        add_token(CH_ADD);
        close_expression();
        add_int_min();
        add_text("01-*");
        close_expression();
        add_int_min();
        add_text("01-^");
        close_expression();
        run_script();
    endtask

    task automatic test_deep_stack();
        // full stack, then reduce without division
        repeat (STACK_DEPTH) add_token(random_operand());
        close_expression();
        repeat (STACK_DEPTH) add_token(random_operand());
        repeat (STACK_DEPTH - 1)
        begin
            case ($urandom_range(0, 3))
                0:       add_token(CH_MUL);
                1:       add_token(CH_ADD);
                2:       add_token(CH_SUB);
                default: add_token(CH_XOR);
            endcase
        end
        close_expression();
        // one push too many, later tokens ignored
        repeat (STACK_DEPTH + 1) add_token(random_operand());
        add_text("++");
        close_expression();
        run_script();
        send_text("12+");
    endtask

    task automatic test_random_traffic();
        int start;
        int r;
        int n;
        start = live_items;
        while (live_items - start < RANDOM_ITEMS)
        begin
            steady_source = ($urandom_range(0, 4) == 0);
            r = $urandom_range(0, 99);
            if (r < 72)
            begin
                add_well_formed($urandom_range(1, 8));
                close_expression();
            end
            else if (r < 75)
            begin
                add_well_formed($urandom_range(9, 30));
                close_expression();
            end
            else if (r < 85)
            begin
                // broken expression: extra operator, extra operand or missing token
                add_well_formed($urandom_range(1, 6));
                case ($urandom_range(0, 2))
                    0: add_token(random_operator());
                    1: add_token(random_operand());
                    default:
                    begin
                        if (token_script.size() > 1)
                            void'(token_script.pop_back());
                    end
                endcase
                close_expression();
            end
            else if (r < 98)
            begin
                // raw bytes with scattered end flags
                repeat ($urandom_range(1, 6))
                    token_script.push_back({1'($urandom_range(0, 3) == 0),
                                            8'($urandom_range(0, 255))});
            end
            else
            begin
                n = $urandom_range(STACK_DEPTH - 4, STACK_DEPTH + 6);
                repeat (n) add_token(random_operand());
                repeat (n - 1) add_token(random_operator());
                close_expression();
            end
            run_script();
        end
        steady_source = 1'b0;
    endtask

    initial
    begin : main_sequence
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        test_operators();
        test_field_extremes();
        test_error_cases();
        test_wrap_cases();
        test_deep_stack();
        test_random_traffic();
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("tb_postfix_expression_evaluator_top passed");
        else
            $display("tb_postfix_expression_evaluator_top failed");
        $finish;
    end

    initial
    begin : watchdog
        #TIMEOUT_TICKS;
        $display("tb_postfix_expression_evaluator_top failed");
        $finish;
    end

endmodule

[postfix_expression_evaluator_top.f]
src/pee_pkg.sv
src/pee_div.sv
src/pee_datapath.sv
src/pee_ctrl.sv
src/postfix_expression_evaluator_top.sv
verif/tb_postfix_expression_evaluator_top.sv
